// ----- rtl/svp_pkg.sv -----
// svp_pkg: shared types and constants of the distance-field validity penalty block
// no dependencies
`timescale 1ns / 1ps

package svp_pkg;

    localparam int SVP_MAX_SIZE = 64;

    localparam int SIZE_W   = 7;
    localparam int LEVEL_W  = 8;
    localparam int LIMIT_W  = 12;
    localparam int COUNT_W  = 13;
    localparam int BRIGHT_W = 16;
    localparam int SLOPE_W  = 26;
    localparam int PIXEL_W  = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_SIZE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_LEVEL      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ON_LEVEL       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AXIAL_LIMIT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIAGONAL_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_ON_COUNT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ON_COUNT   = 3'd6;

    localparam logic [SIZE_W-1:0]  RST_IMAGE_SIZE     = 7'd36;
    localparam logic [LEVEL_W-1:0] RST_OFF_LEVEL      = 8'd64;
    localparam logic [LEVEL_W-1:0] RST_ON_LEVEL       = 8'd220;
    localparam logic [LIMIT_W-1:0] RST_AXIAL_LIMIT    = 12'd240;
    localparam logic [LIMIT_W-1:0] RST_DIAGONAL_LIMIT = 12'd339;
    localparam logic [COUNT_W-1:0] RST_MIN_ON_COUNT   = 13'd129;
    localparam logic [COUNT_W-1:0] RST_MAX_ON_COUNT   = 13'd648;

    typedef struct packed {
        logic [SIZE_W-1:0]  image_size;
        logic [LEVEL_W-1:0] off_level;
        logic [LEVEL_W-1:0] on_level;
        logic [LIMIT_W-1:0] axial_limit;
        logic [LIMIT_W-1:0] diagonal_limit;
        logic [COUNT_W-1:0] min_on_count;
        logic [COUNT_W-1:0] max_on_count;
    } cfg_t;

    typedef struct packed {
        logic               valid;
        logic [PIXEL_W-1:0] pixel;
        logic               border;
        logic               use_left;
        logic               use_up;
        logic               use_diag;
        logic               frame_end;
    } stage_t;

endpackage

// ----- rtl/sdf_validity_penalty_top.sv -----
// sdf_validity_penalty_top: top level of the distance-field validity penalty block
// depends on svp_pkg, svp_cfg, svp_scan, svp_ram, svp_accum
`timescale 1ns / 1ps

// Takes a square image of image_size x image_size 8-bit pixels in raster order, one word
// per cycle while in_ready is high, and after the last pixel delivers one result word
// with the border brightness penalty, the on-count band penalty, the neighbor slope
// penalty and a feasible flag. Each pixel is registered with its position on acceptance
// while the previous row's pixel is read from the one-row line buffer; when the pixel
// leaves the input register the accumulators are updated and the pixel written back. The
// result word is registered as the last pixel leaves the input register. The last pixel of
// an image waits in the input register while the previous result word has not been taken,
// which holds off further input. image_size is clamped to 3..MAX_SIZE; configuration must
// be written between images while the block is idle, which the block does not enforce.

module sdf_validity_penalty_top
    import svp_pkg::*;
#(
    parameter int MAX_SIZE = SVP_MAX_SIZE
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [PIXEL_W-1:0]    pixel,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [BRIGHT_W-1:0]   bright_sum,
    output logic [COUNT_W-1:0]    boring_amount,
    output logic [SLOPE_W-1:0]    slope_sum,
    output logic                  feasible
);

    localparam int CW = $clog2(MAX_SIZE);

    cfg_t               cfg;
    stage_t             stage;
    logic [CW-1:0]      stage_idx;
    logic               stage_go;
    logic               rd_en, wr_en;
    logic [CW-1:0]      rd_addr, wr_addr;
    logic [PIXEL_W-1:0] wr_data, up_pixel;

    svp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    svp_scan #(
        .MAX_SIZE (MAX_SIZE)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .pixel     (pixel),
        .stage_go  (stage_go),
        .stage     (stage),
        .stage_idx (stage_idx),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr)
    );

    svp_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (MAX_SIZE)
    ) u_row_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (up_pixel)
    );

    svp_accum #(
        .MAX_SIZE (MAX_SIZE)
    ) u_accum (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .stage         (stage),
        .stage_idx     (stage_idx),
        .up_pixel      (up_pixel),
        .stage_go      (stage_go),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .bright_sum    (bright_sum),
        .boring_amount (boring_amount),
        .slope_sum     (slope_sum),
        .feasible      (feasible)
    );

endmodule

// ----- rtl/svp_ram.sv -----
// svp_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module svp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/svp_cfg.sv -----
// svp_cfg: configuration register file written through the plain write port
// depends on svp_pkg
`timescale 1ns / 1ps

module svp_cfg
    import svp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_IMAGE_SIZE:     cfg_next.image_size     = cfg_data[SIZE_W-1:0];
                REG_OFF_LEVEL:      cfg_next.off_level      = cfg_data[LEVEL_W-1:0];
                REG_ON_LEVEL:       cfg_next.on_level       = cfg_data[LEVEL_W-1:0];
                REG_AXIAL_LIMIT:    cfg_next.axial_limit    = cfg_data[LIMIT_W-1:0];
                REG_DIAGONAL_LIMIT: cfg_next.diagonal_limit = cfg_data[LIMIT_W-1:0];
                REG_MIN_ON_COUNT:   cfg_next.min_on_count   = cfg_data[COUNT_W-1:0];
                REG_MAX_ON_COUNT:   cfg_next.max_on_count   = cfg_data[COUNT_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_size     <= RST_IMAGE_SIZE;
            cfg_reg.off_level      <= RST_OFF_LEVEL;
            cfg_reg.on_level       <= RST_ON_LEVEL;
            cfg_reg.axial_limit    <= RST_AXIAL_LIMIT;
            cfg_reg.diagonal_limit <= RST_DIAGONAL_LIMIT;
            cfg_reg.min_on_count   <= RST_MIN_ON_COUNT;
            cfg_reg.max_on_count   <= RST_MAX_ON_COUNT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/svp_scan.sv -----
// svp_scan: input register, raster position counters and line buffer read address
// depends on svp_pkg
`timescale 1ns / 1ps

module svp_scan
    import svp_pkg::*;
#(
    parameter int MAX_SIZE = SVP_MAX_SIZE
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  cfg_t                        cfg,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [PIXEL_W-1:0]          pixel,
    input  logic                        stage_go,
    output stage_t                      stage,
    output logic [$clog2(MAX_SIZE)-1:0] stage_idx,
    output logic                        rd_en,
    output logic [$clog2(MAX_SIZE)-1:0] rd_addr
);

    localparam int CW = $clog2(MAX_SIZE);
    localparam int SW = (CW + 1 > 8) ? CW + 1 : 8;

    logic [CW-1:0] col_reg, col_next;
    logic [CW-1:0] row_reg, row_next;
    stage_t        stage_reg, stage_next;
    logic [CW-1:0] idx_reg;

    logic [SW-1:0] size_ext, eff, last, col_ext, row_ext;
    logic          row_end, frame_end, accept;

    always_comb
    begin
        size_ext = SW'(cfg.image_size);
        if (size_ext < SW'(3))
        begin
            eff = SW'(3);
        end
        else if (size_ext > SW'(MAX_SIZE))
        begin
            eff = SW'(MAX_SIZE);
        end
        else
        begin
            eff = size_ext;
        end
        last      = eff - SW'(1);
        col_ext   = SW'(col_reg);
        row_ext   = SW'(row_reg);
        row_end   = col_ext >= last;
        frame_end = row_end && (row_ext >= last);
    end

    assign in_ready = !stage_reg.valid || stage_go;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        stage_next = stage_reg;
        if (accept)
        begin
            if (row_end)
            begin
                col_next = '0;
                row_next = frame_end ? '0 : row_reg + CW'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
            stage_next.valid     = 1'b1;
            stage_next.pixel     = pixel;
            stage_next.border    = (row_reg == '0) || (row_ext >= last)
                                   || (col_reg == '0) || row_end;
            stage_next.use_left  = (col_reg != '0) && (row_ext < last);
            stage_next.use_up    = (row_reg != '0) && !row_end;
            stage_next.use_diag  = (col_reg != '0) && (row_reg != '0);
            stage_next.frame_end = frame_end;
        end
        else if (stage_go)
        begin
            stage_next.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            stage_reg <= '0;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            stage_reg <= stage_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            idx_reg <= col_reg;
        end
    end

    assign stage     = stage_reg;
    assign stage_idx = idx_reg;
    assign rd_en     = accept;
    assign rd_addr   = col_reg;

endmodule

// ----- rtl/svp_accum.sv -----
// svp_accum: penalty accumulators, line buffer write-back and result register
// depends on svp_pkg
`timescale 1ns / 1ps

module svp_accum
    import svp_pkg::*;
#(
    parameter int MAX_SIZE = SVP_MAX_SIZE
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  cfg_t                        cfg,
    input  stage_t                      stage,
    input  logic [$clog2(MAX_SIZE)-1:0] stage_idx,
    input  logic [PIXEL_W-1:0]          up_pixel,
    output logic                        stage_go,
    output logic                        wr_en,
    output logic [$clog2(MAX_SIZE)-1:0] wr_addr,
    output logic [PIXEL_W-1:0]          wr_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [BRIGHT_W-1:0]         bright_sum,
    output logic [COUNT_W-1:0]          boring_amount,
    output logic [SLOPE_W-1:0]          slope_sum,
    output logic                        feasible
);

    localparam int EX_W = LIMIT_W + 2;

    logic [PIXEL_W-1:0]  left_reg, upleft_reg;
    logic [BRIGHT_W-1:0] bright_reg, bright_next;
    logic [COUNT_W-1:0]  on_reg, on_next;
    logic [SLOPE_W-1:0]  slope_reg, slope_next;

    logic                out_valid_reg;
    logic [BRIGHT_W-1:0] bright_sum_reg;
    logic [COUNT_W-1:0]  boring_reg, boring;
    logic [SLOPE_W-1:0]  slope_sum_reg;
    logic                feasible_reg;

    logic [LIMIT_W-1:0]  ex_left, ex_up, ex_diag;
    logic [EX_W-1:0]     ex_total;
    logic [BRIGHT_W:0]   bright_wide;
    logic [SLOPE_W:0]    slope_wide;
    logic                fire;

    function automatic logic [LIMIT_W-1:0] excess(
        input logic [PIXEL_W-1:0] a,
        input logic [PIXEL_W-1:0] b,
        input logic [LIMIT_W-1:0] limit
    );
        logic [PIXEL_W-1:0] diff;
        logic [LIMIT_W-1:0] d;
        diff = (a > b) ? a - b : b - a;
        d    = {diff, 4'b0000};
        return (d > limit) ? d - limit : '0;
    endfunction

    assign stage_go = !(stage.frame_end && out_valid_reg && !out_ready);
    assign fire     = stage.valid && stage_go;

    always_comb
    begin
        ex_left  = stage.use_left ? excess(stage.pixel, left_reg, cfg.axial_limit) : '0;
        ex_up    = stage.use_up ? excess(stage.pixel, up_pixel, cfg.axial_limit) : '0;
        ex_diag  = stage.use_diag ? excess(stage.pixel, upleft_reg, cfg.diagonal_limit) : '0;
        ex_total = EX_W'(ex_left) + EX_W'(ex_up) + EX_W'(ex_diag);

        slope_wide = (SLOPE_W + 1)'(slope_reg) + (SLOPE_W + 1)'(ex_total);
        slope_next = slope_wide[SLOPE_W] ? '1 : slope_wide[SLOPE_W-1:0];

        if (stage.border && (stage.pixel > cfg.off_level))
        begin
            bright_wide = (BRIGHT_W + 1)'(bright_reg)
                          + (BRIGHT_W + 1)'(stage.pixel - cfg.off_level);
        end
        else
        begin
            bright_wide = (BRIGHT_W + 1)'(bright_reg);
        end
        bright_next = bright_wide[BRIGHT_W] ? '1 : bright_wide[BRIGHT_W-1:0];

        if ((stage.pixel >= cfg.on_level) && (on_reg != '1))
        begin
            on_next = on_reg + COUNT_W'(1);
        end
        else
        begin
            on_next = on_reg;
        end

        if (on_next < cfg.min_on_count)
        begin
            boring = cfg.min_on_count - on_next;
        end
        else if (on_next > cfg.max_on_count)
        begin
            boring = on_next - cfg.max_on_count;
        end
        else
        begin
            boring = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bright_reg    <= '0;
            on_reg        <= '0;
            slope_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                if (stage.frame_end)
                begin
                    bright_reg <= '0;
                    on_reg     <= '0;
                    slope_reg  <= '0;
                end
                else
                begin
                    bright_reg <= bright_next;
                    on_reg     <= on_next;
                    slope_reg  <= slope_next;
                end
            end
            if (fire && stage.frame_end)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // previous pixel and up-left neighbor, only read when the position allows
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            left_reg   <= stage.pixel;
            upleft_reg <= up_pixel;
        end
        if (fire && stage.frame_end)
        begin
            bright_sum_reg <= bright_next;
            boring_reg     <= boring;
            slope_sum_reg  <= slope_next;
            feasible_reg   <= (bright_next == '0) && (boring == '0) && (slope_next == '0);
        end
    end

    assign wr_en         = fire;
    assign wr_addr       = stage_idx;
    assign wr_data       = stage.pixel;
    assign out_valid     = out_valid_reg;
    assign bright_sum    = bright_sum_reg;
    assign boring_amount = boring_reg;
    assign slope_sum     = slope_sum_reg;
    assign feasible      = feasible_reg;

endmodule

// ----- dv/tb_sdf_validity_penalty_top.sv -----
// tb_sdf_validity_penalty_top: self-checking testbench of the distance-field validity penalty block
// streams whole images through the pixel port, predicts each result word, checks it field by field
// depends on svp_pkg and sdf_validity_penalty_top
`timescale 1ns / 1ps

module tb_sdf_validity_penalty_top;
    import svp_pkg::*;

    localparam int unsigned BRIGHT_CAP   = (1 << BRIGHT_W) - 1;
    localparam int unsigned COUNT_CAP    = (1 << COUNT_W) - 1;
    localparam int unsigned SLOPE_CAP    = (1 << SLOPE_W) - 1;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          RANDOM_PIXELS = 300;
    localparam int          RANDOM_IMAGES = 12;

    typedef struct {
        logic [BRIGHT_W-1:0] bright;
        logic [COUNT_W-1:0]  boring;
        logic [SLOPE_W-1:0]  slope;
        logic                feasible;
    } penalty_t;

    typedef enum int {MODE_UNIFORM, MODE_RAMP, MODE_FLAT, MODE_EXTREME, MODE_DARK_EDGE} fill_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [PIXEL_W-1:0]    pixel = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [BRIGHT_W-1:0]   bright_sum;
    logic [COUNT_W-1:0]    boring_amount;
    logic [SLOPE_W-1:0]    slope_sum;
    logic                  feasible;

    // predictor state
    cfg_t               model_cfg;
    logic [PIXEL_W-1:0] line_above [SVP_MAX_SIZE];
    int unsigned        left_px;
    int unsigned        upleft_px;
    int unsigned        scan_col;
    int unsigned        scan_row;
    int unsigned        bright_acc;
    int unsigned        on_count;
    int unsigned        slope_acc;
    penalty_t           penalty_q [$];

    bit   in_gaps = 1'b1;
    bit   out_gaps = 1'b1;
    logic hold_toggle = 1'b0;
    logic hold_seen = 1'b0;
    int   hold_count = 0;

    int fail_count = 0;
    int pixels_sent = 0;
    int images_checked = 0;
    int feasible_seen = 0;
    int side_min = SVP_MAX_SIZE;
    int side_max = 0;

    sdf_validity_penalty_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .pixel         (pixel),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .bright_sum    (bright_sum),
        .boring_amount (boring_amount),
        .slope_sum     (slope_sum),
        .feasible      (feasible)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int unsigned side_of(cfg_t s);
        if (s.image_size < 3)
            return 3;
        if (s.image_size > SVP_MAX_SIZE)
            return SVP_MAX_SIZE;
        return s.image_size;
    endfunction

    function automatic void clear_image();
        left_px = 0;
        upleft_px = 0;
        scan_col = 0;
        scan_row = 0;
        bright_acc = 0;
        on_count = 0;
        slope_acc = 0;
    endfunction

    function automatic void reset_model();
        model_cfg = '{image_size: RST_IMAGE_SIZE, off_level: RST_OFF_LEVEL,
                      on_level: RST_ON_LEVEL, axial_limit: RST_AXIAL_LIMIT,
                      diagonal_limit: RST_DIAGONAL_LIMIT, min_on_count: RST_MIN_ON_COUNT,
                      max_on_count: RST_MAX_ON_COUNT};
        foreach (line_above[i])
            line_above[i] = '0;
        clear_image();
    endfunction

    function automatic void add_slope(int unsigned a, int unsigned b, int unsigned limit);
        int unsigned d;
        d = (a > b ? a - b : b - a) * 16;
        if (d > limit)
        begin
            slope_acc += d - limit;
            if (slope_acc > SLOPE_CAP)
                slope_acc = SLOPE_CAP;
        end
    endfunction

    function automatic void accumulate_pixel(logic [PIXEL_W-1:0] value);
        int unsigned p;
        int unsigned last;
        int unsigned c;
        int unsigned r;
        int unsigned idx;
        int unsigned up;
        int unsigned boring;
        penalty_t    res;
        p = value;
        last = side_of(model_cfg) - 1;
        c = scan_col;
        r = scan_row;
        idx = (c < SVP_MAX_SIZE) ? c : SVP_MAX_SIZE - 1;
        up = line_above[idx];

        if ((r == 0 || r >= last || c == 0 || c >= last) && p > model_cfg.off_level)
        begin
            bright_acc += p - model_cfg.off_level;
            if (bright_acc > BRIGHT_CAP)
                bright_acc = BRIGHT_CAP;
        end
        if (p >= model_cfg.on_level && on_count < COUNT_CAP)
            on_count++;

        if (c >= 1 && r < last)
            add_slope(p, left_px, model_cfg.axial_limit);
        if (r >= 1 && c < last)
            add_slope(p, up, model_cfg.axial_limit);
        if (c >= 1 && r >= 1)
            add_slope(p, upleft_px, model_cfg.diagonal_limit);

        line_above[idx] = value;
        upleft_px = up;
        left_px = p;

        if (c < last)
        begin
            scan_col = c + 1;
            return;
        end
        scan_col = 0;
        left_px = 0;
        upleft_px = 0;
        if (r < last)
        begin
            scan_row = r + 1;
            return;
        end

        boring = 0;
        if (on_count < model_cfg.min_on_count)
            boring = model_cfg.min_on_count - on_count;
        else if (on_count > model_cfg.max_on_count)
            boring = on_count - model_cfg.max_on_count;
        res.bright = BRIGHT_W'(bright_acc);
        res.boring = COUNT_W'(boring);
        res.slope = SLOPE_W'(slope_acc);
        res.feasible = (bright_acc == 0 && boring == 0 && slope_acc == 0);
        penalty_q.insert(penalty_q.size(), res);
        clear_image();
    endfunction

    function automatic void check_result();
        penalty_t want;
        if (penalty_q.size() == 0)
        begin
            $error("result word with no image pending");
            fail_count++;
            return;
        end
        want = penalty_q.pop_front();
        if (bright_sum !== want.bright)
        begin
            $error("bright_sum expected %0d actual %0d", want.bright, bright_sum);
            fail_count++;
        end
        if (boring_amount !== want.boring)
        begin
            $error("boring_amount expected %0d actual %0d", want.boring, boring_amount);
            fail_count++;
        end
        if (slope_sum !== want.slope)
        begin
            $error("slope_sum expected %0d actual %0d", want.slope, slope_sum);
            fail_count++;
        end
        if (feasible !== want.feasible)
        begin
            $error("feasible expected %0d actual %0d", want.feasible, feasible);
            fail_count++;
        end
        images_checked++;
        if (want.feasible)
            feasible_seen++;
    endfunction

    // receiver: random stalls, long hold on request, result check
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_result();
            if (hold_toggle != hold_seen)
            begin
                hold_seen <= hold_toggle;
                hold_count <= HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else if (hold_count != 0)
            begin
                hold_count <= hold_count - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= !(out_gaps && $urandom_range(0, 99) < 24);
            end
        end
    end

    task automatic send_pixel(input logic [PIXEL_W-1:0] value);
        while (in_gaps && $urandom_range(0, 99) < 24)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel <= value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        accumulate_pixel(value);
        pixels_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (penalty_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(value);
        @(posedge clk);
        case (idx)
            REG_IMAGE_SIZE:     model_cfg.image_size = SIZE_W'(value);
            REG_OFF_LEVEL:      model_cfg.off_level = LEVEL_W'(value);
            REG_ON_LEVEL:       model_cfg.on_level = LEVEL_W'(value);
            REG_AXIAL_LIMIT:    model_cfg.axial_limit = LIMIT_W'(value);
            REG_DIAGONAL_LIMIT: model_cfg.diagonal_limit = LIMIT_W'(value);
            REG_MIN_ON_COUNT:   model_cfg.min_on_count = COUNT_W'(value);
            REG_MAX_ON_COUNT:   model_cfg.max_on_count = COUNT_W'(value);
            default: ;
        endcase
    endtask

    task automatic write_settings(input cfg_t s);
        write_reg(REG_IMAGE_SIZE, s.image_size);
        write_reg(REG_OFF_LEVEL, s.off_level);
        write_reg(REG_ON_LEVEL, s.on_level);
        write_reg(REG_AXIAL_LIMIT, s.axial_limit);
        write_reg(REG_DIAGONAL_LIMIT, s.diagonal_limit);
        write_reg(REG_MIN_ON_COUNT, s.min_on_count);
        write_reg(REG_MAX_ON_COUNT, s.max_on_count);
        cfg_write <= 1'b0;
    endtask

    function automatic cfg_t random_settings(int unsigned size);
        cfg_t        s;
        int unsigned area;
        s.image_size = SIZE_W'(size);
        area = side_of(s) * side_of(s);
        if ($urandom_range(0, 4) == 0)
        begin
            // lenient settings, always feasible images
            s.off_level = 8'd255;
            s.on_level = LEVEL_W'($urandom_range(0, 255));
            s.axial_limit = 12'd4095;
            s.diagonal_limit = 12'd4095;
            s.min_on_count = '0;
            s.max_on_count = 13'd4096;
        end
        else
        begin
            s.off_level = LEVEL_W'($urandom_range(0, 255));
            s.on_level = LEVEL_W'($urandom_range(0, 255));
            s.axial_limit = LIMIT_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                                 : $urandom_range(0, 300));
            s.diagonal_limit = LIMIT_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                                    : $urandom_range(0, 450));
            s.min_on_count = COUNT_W'(($urandom_range(0, 7) == 0) ? 4096
                                                                  : $urandom_range(0, area));
            s.max_on_count = COUNT_W'(($urandom_range(0, 3) == 0) ? 4096
                                                                  : $urandom_range(0, area));
        end
        return s;
    endfunction

    function automatic logic [PIXEL_W-1:0] pixel_at(fill_t mode, int x, int y, int n,
                                                     int base, int sx, int sy);
        int v;
        case (mode)
            MODE_UNIFORM:  v = $urandom_range(0, 255);
            MODE_FLAT:     v = base;
            MODE_EXTREME:  v = $urandom_range(0, 1) ? 255 : 0;
            MODE_DARK_EDGE:
                if (x == 0 || y == 0 || x == n - 1 || y == n - 1)
                    v = $urandom_range(0, 8);
                else
                    v = base + x * sx + y * sy + $urandom_range(0, 2);
            default:       v = base + x * sx + y * sy + $urandom_range(0, 2);
        endcase
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return PIXEL_W'(v);
    endfunction

    task automatic send_image(input fill_t mode);
        int n;
        int base;
        int sx;
        int sy;
        n = side_of(model_cfg);
        base = $urandom_range(0, 255);
        sx = int'($urandom_range(0, 16)) - 8;
        sy = int'($urandom_range(0, 16)) - 8;
        if (n < side_min)
            side_min = n;
        if (n > side_max)
            side_max = n;
        for (int y = 0; y < n; y++)
            for (int x = 0; x < n; x++)
                send_pixel(pixel_at(mode, x, y, n, base, sx, sy));
    endtask

    task automatic test_reset_values();
        send_image(MODE_RAMP);
        wait_idle();
    endtask

    task automatic test_directed_extremes();
        cfg_t s;
        // strictest limits, checkerboard of the pixel extremes
        s = '{image_size: 7'd3, off_level: 8'd0, on_level: 8'd255, axial_limit: 12'd0,
              diagonal_limit: 12'd0, min_on_count: 13'd0, max_on_count: 13'd4096};
        write_settings(s);
        for (int y = 0; y < 3; y++)
            for (int x = 0; x < 3; x++)
                send_pixel(((x + y) % 2) ? 8'd255 : 8'd0);
        wait_idle();
        // size below minimum, loosest limits, inverted band
        s = '{image_size: 7'd0, off_level: 8'd255, on_level: 8'd0, axial_limit: 12'd4095,
              diagonal_limit: 12'd4095, min_on_count: 13'd4096, max_on_count: 13'd0};
        write_settings(s);
        repeat (9) send_pixel(8'd255);
        wait_idle();
        // feasible image: one on pixel in the middle, slopes exactly at the limits
        s = '{image_size: 7'd1, off_level: 8'd128, on_level: 8'd1, axial_limit: 12'd16,
              diagonal_limit: 12'd16, min_on_count: 13'd1, max_on_count: 13'd1};
        write_settings(s);
        for (int y = 0; y < 3; y++)
            for (int x = 0; x < 3; x++)
                send_pixel((x == 1 && y == 1) ? 8'd1 : 8'd0);
        wait_idle();
    endtask

    task automatic test_size_limits();
        write_settings(random_settings(0));
        send_image(fill_t'($urandom_range(0, 4)));
        wait_idle();
        write_settings(random_settings(2));
        send_image(fill_t'($urandom_range(0, 4)));
        wait_idle();
    endtask

    task automatic test_backpressure();
        write_settings(random_settings(3));
        in_gaps = 1'b0;
        hold_toggle <= ~hold_toggle;
        repeat (12) send_image(MODE_UNIFORM);
        wait_idle();
        in_gaps = 1'b1;
    endtask

    task automatic test_random_images();
        int images;
        int start;
        int r;
        int unsigned size;
        images = 0;
        start = pixels_sent;
        while (pixels_sent - start < RANDOM_PIXELS || images < RANDOM_IMAGES)
        begin
            if (images % 5 == 0)
            begin
                wait_idle();
                r = $urandom_range(0, 99);
                if (r < 10)
                    size = $urandom_range(0, 2);
                else if (r < 90)
                    size = $urandom_range(3, 6);
                else
                    size = $urandom_range(7, 10);
                write_settings(random_settings(size));
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                wait_idle();
            end
            // stretch with no idling on either side
            if (images == 1)
            begin
                in_gaps = 1'b0;
                out_gaps <= 1'b0;
            end
            else if (images == 5)
            begin
                in_gaps = 1'b1;
                out_gaps <= 1'b1;
            end
            send_image(fill_t'($urandom_range(0, 4)));
            images++;
        end
        wait_idle();
    endtask

    initial
    begin
        reset_model();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_directed_extremes();
        test_size_limits();
        test_backpressure();
        test_random_images();

        if (penalty_q.size() != 0)
        begin
            $error("%0d result words never arrived", penalty_q.size());
            fail_count++;
        end
        $display("checked %0d images (%0d feasible) from %0d pixels, side lengths %0d to %0d",
                 images_checked, feasible_seen, pixels_sent, side_min, side_max);
        $display("covered reset defaults, clamped sizes, inverted band and a %0d-cycle output hold",
                 HOLD_CYCLES);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("timeout waiting for the block");
        $display("Test completed with failures");
        $finish;
    end

endmodule
